>>> src/ccs_pkg.sv
// Shared constants, codes and saturation helper for the complex cubic spline evaluator.
package ccs_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_W = 296;
  localparam int OUT_W = 200;
  localparam int CFG_W = 32;
  localparam int SW = 72;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_GIVEN = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
  localparam logic [1:0] REG_RANGE_LOW = 2'd1;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if ((&v[SW-1:31]) || (~|v[SW-1:31])) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

>>> src/ccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ccs_arith.sv
// Seven-stage pipeline for one part of the spline value and its two derivatives.
module ccs_arith import ccs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  input  logic signed [31:0] knot,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  input  logic signed [31:0] d,
  output logic signed [31:0] value,
  output logic signed [31:0] deriv,
  output logic signed [31:0] curv
);

  logic signed [32:0] t1, t2, t3, t4, t5;
  logic signed [31:0] a1, b1, b2, c1, c2, c3, c4, d1, d2, d3, d4, d5, d6;
  logic signed [64:0] pa, pg, ph, pv;
  logic signed [31:0] g3, h3, h5, curv3, curv4, curv5, curv6, deriv5, deriv6;
  logic signed [31:0] ta;

  assign ta = sat32(SW'(pa >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= 33'(x) - 33'(knot);
      a1 <= a;
      b1 <= b;
      c1 <= c;
      d1 <= d;

      pa <= 65'(a1) * 65'(t1);
      t2 <= t1;
      b2 <= b1;
      c2 <= c1;
      d2 <= d1;

      curv3 <= sat32((SW'(ta) <<< 2) + (SW'(ta) <<< 1) + (SW'(b2) <<< 1));
      g3 <= sat32((SW'(ta) <<< 1) + SW'(ta) + (SW'(b2) <<< 1));
      h3 <= sat32(SW'(ta) + SW'(b2));
      t3 <= t2;
      c3 <= c2;
      d3 <= d2;

      pg <= 65'(g3) * 65'(t3);
      ph <= 65'(h3) * 65'(t3);
      t4 <= t3;
      c4 <= c3;
      d4 <= d3;
      curv4 <= curv3;

      deriv5 <= sat32(SW'(pg >>> FRAC_BITS) + SW'(c4));
      h5 <= sat32(SW'(ph >>> FRAC_BITS) + SW'(c4));
      t5 <= t4;
      d5 <= d4;
      curv5 <= curv4;

      pv <= 65'(h5) * 65'(t5);
      d6 <= d5;
      deriv6 <= deriv5;
      curv6 <= curv5;

      value <= sat32(SW'(pv >>> FRAC_BITS) + SW'(d6));
      deriv <= deriv6;
      curv <= curv6;
    end
  end

endmodule

>>> src/complex_cubic_spline_evaluator.sv
// Complex cubic spline evaluator top level: segment search pipeline, table and output.
//
// The block takes one transfer per clock while the output is not stalled and returns one
// result per transfer, in order. Each result passes one stage for decode and range checks,
// one knot table copy per binary search step, one stage for the coefficient read and seven
// arithmetic stages. Each search step reads its own copy of the knot table, and a load
// writes every copy as it passes the matching stage, so loads and evaluations may be
// mixed freely. The whole pipeline advances together and holds while a finished result
// is not taken.
module complex_cubic_spline_evaluator import ccs_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // action, segment, position, cubic_re, cubic_im, square_re, square_im,
  // slope_re, slope_im, offset_re, offset_im
  input  logic [IN_W-1:0]  s_tdata,
  // allow_extrapolate
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // value_re, value_im, deriv_re, deriv_im, curv_re, curv_im, used_segment, zero fill
  output logic [OUT_W-1:0] m_tdata,
  // status
  output logic             m_tuser,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SL = IW;
  localparam int LW = 288;
  localparam int DL = 7;

  typedef struct packed {
    logic               valid;
    logic               eval;
    logic               status;
    logic [5:0]         useg;
    logic               we;
    logic signed [31:0] x;
    logic [IW-1:0]      lo;
    logic [CW-1:0]      hi;
    logic [LW-1:0]      ldata;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic       status;
    logic [5:0] useg;
  } ctrl_t;

  logic [6:0]         segment_count;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  logic               en;
  item_t              in_item;
  item_t              st [SL+1];
  item_t              post [SL+1];
  item_t              r1;
  logic [31:0]        knot_rd [SL];
  logic [LW-1:0]      fin_rd;
  ctrl_t              dl [DL];

  logic [1:0]         action;
  logic [5:0]         segment;
  logic signed [31:0] position;
  logic [CW-1:0]      n_eff;
  logic [IW-1:0]      n_last;
  logic               seg_ok;
  logic               seg_big;
  logic               out_range;

  logic signed [31:0] value_re, value_im, deriv_re, deriv_im, curv_re, curv_im;

  function automatic logic [IW-1:0] mid_of(input item_t s);
    logic [CW:0] sum;
    sum = (CW+1)'(s.lo) + (CW+1)'(s.hi);
    return IW'(sum >> 1);
  endfunction

  function automatic item_t search_step(input item_t s, input logic signed [31:0] knot);
    item_t r;
    r = s;
    if (s.eval && ((CW+1)'(s.hi) > (CW+1)'(s.lo) + (CW+1)'(1))) begin
      if (s.x >= knot) begin
        r.lo = mid_of(s);
      end else begin
        r.hi = CW'(mid_of(s));
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 7'd1;
      range_low <= '0;
      range_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEGMENT_COUNT: segment_count <= cfg_data[6:0];
        REG_RANGE_LOW:     range_low <= cfg_data;
        REG_RANGE_HIGH:    range_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign action = s_tdata[1:0];
  assign segment = s_tdata[7:2];
  assign position = s_tdata[39:8];

  always_comb begin
    if (segment_count == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(segment_count) > 32'(MAX_SEGMENTS)) begin
      n_eff = CW'(MAX_SEGMENTS);
    end else begin
      n_eff = CW'(segment_count);
    end
  end

  assign n_last = IW'(n_eff - CW'(1));
  assign seg_ok = 32'(segment) < 32'(MAX_SEGMENTS);
  assign seg_big = 32'(segment) > 32'(n_last);
  assign out_range = !s_tuser && ((position < range_low) || (position > range_high));

  always_comb begin
    in_item = '0;
    in_item.valid = s_tvalid;
    in_item.x = position;
    in_item.ldata = {s_tdata[295:40], s_tdata[39:8]};
    in_item.hi = CW'(1);
    unique case (action)
      ACT_LOAD: begin
        in_item.we = seg_ok;
        in_item.status = !seg_ok;
        in_item.useg = segment;
        in_item.lo = IW'(segment);
      end
      ACT_SEARCH: begin
        if (out_range) begin
          in_item.status = 1'b1;
        end else begin
          in_item.eval = 1'b1;
          if (position >= range_high) begin
            in_item.lo = n_last;
            in_item.hi = n_eff;
          end else if (position > range_low) begin
            in_item.hi = n_eff;
          end
        end
      end
      ACT_GIVEN: begin
        in_item.eval = 1'b1;
        in_item.lo = seg_big ? n_last : IW'(segment);
        in_item.hi = CW'(in_item.lo) + CW'(1);
      end
      default: begin
        in_item.status = 1'b1;
      end
    endcase
  end

  assign en = !dl[DL-1].valid || m_tready;
  assign s_tready = en;

  assign post[0] = st[0];
  for (genvar k = 1; k <= SL; k++) begin : g_step
    assign post[k] = search_step(st[k], knot_rd[k-1]);
  end

  for (genvar k = 0; k < SL; k++) begin : g_knot
    ccs_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_knot (
      .clk   (clk),
      .we    (en && st[k].valid && st[k].we),
      .waddr (st[k].lo),
      .wdata (st[k].ldata[31:0]),
      .re    (en),
      .raddr (mid_of(post[k])),
      .rdata (knot_rd[k])
    );
  end

  ccs_ram #(.WIDTH(LW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (en && st[SL].valid && st[SL].we),
    .waddr (st[SL].lo),
    .wdata (st[SL].ldata),
    .re    (en),
    .raddr (post[SL].lo),
    .rdata (fin_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SL; k++) begin
        st[k].valid <= 1'b0;
      end
      r1.valid <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        dl[k].valid <= 1'b0;
      end
    end else if (en) begin
      st[0] <= in_item;
      for (int k = 1; k <= SL; k++) begin
        st[k] <= post[k-1];
      end
      r1 <= post[SL];
      dl[0].valid <= r1.valid;
      dl[0].zero <= !r1.eval;
      dl[0].status <= r1.status;
      dl[0].useg <= r1.eval ? 6'(r1.lo) : r1.useg;
      for (int k = 1; k < DL; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  ccs_arith #(.FRAC_BITS(FRAC_BITS)) u_arith_re (
    .clk   (clk),
    .en    (en),
    .x     (r1.x),
    .knot  (fin_rd[31:0]),
    .a     (fin_rd[63:32]),
    .b     (fin_rd[127:96]),
    .c     (fin_rd[191:160]),
    .d     (fin_rd[255:224]),
    .value (value_re),
    .deriv (deriv_re),
    .curv  (curv_re)
  );

  ccs_arith #(.FRAC_BITS(FRAC_BITS)) u_arith_im (
    .clk   (clk),
    .en    (en),
    .x     (r1.x),
    .knot  (fin_rd[31:0]),
    .a     (fin_rd[95:64]),
    .b     (fin_rd[159:128]),
    .c     (fin_rd[223:192]),
    .d     (fin_rd[287:256]),
    .value (value_im),
    .deriv (deriv_im),
    .curv  (curv_im)
  );

  assign m_tvalid = dl[DL-1].valid;
  assign m_tuser = dl[DL-1].status;
  assign m_tdata = dl[DL-1].zero ? {2'b00, dl[DL-1].useg, 192'd0}
                                 : {2'b00, dl[DL-1].useg, curv_im, curv_re,
                                    deriv_im, deriv_re, value_im, value_re};

endmodule

>>> src/ccs_check.sv
// Port-level checks for the complex cubic spline evaluator, bound to the top level.
module ccs_check import ccs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             cfg_we,
  input logic [1:0]       cfg_index,
  input logic [CFG_W-1:0] cfg_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[191:0] == 192'd0)
    else $error("refused result carries nonzero values");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

endmodule

bind complex_cubic_spline_evaluator ccs_check u_ccs_check (.*);

>>> tb/tb.sv
// Self-checking testbench for the complex cubic spline evaluator stream block.
module tb;
  import ccs_pkg::*;

  localparam int NSEG = 64;
  localparam int FB = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SEGMENT_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic status;
    logic [5:0] seg;
    logic signed [31:0] curv_im, curv_re, deriv_im, deriv_re, value_im, value_re;
  } spline_result_t;

  complex_cubic_spline_evaluator dut (.*);

  always #5 clk = ~clk;

  logic signed [31:0] knot_tab [NSEG];
  logic signed [31:0] coef_tab [NSEG][8];
  bit loaded [NSEG];
  logic [6:0] count_reg;
  logic signed [31:0] low_reg, high_reg;
  spline_result_t expected_q [$];
  int errors = 0;
  bit recv_idle = 1'b1;
  bit send_idle = 1'b1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h", what, got, want);
  endtask

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FB;
  endfunction

  function automatic int n_active();
    if (count_reg == 0) return 1;
    if (count_reg > NSEG) return NSEG;
    return int'(count_reg);
  endfunction

  function automatic int search_seg(input logic signed [31:0] x);
    int lo, hi, mid;
    lo = 0;
    hi = n_active();
    if (x >= high_reg) return hi - 1;
    if (x <= low_reg) return 0;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (x >= knot_tab[mid]) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic spline_result_t spline_eval(input int s, input logic signed [31:0] x);
    spline_result_t r;
    logic signed [63:0] t, a, b, c, d, ta, cv, g, dv, h1, h2, v;
    r = '0;
    t = 64'(x) - 64'(knot_tab[s]);
    for (int k = 0; k < 2; k++) begin
      a = 64'(coef_tab[s][k]);
      b = 64'(coef_tab[s][2 + k]);
      c = 64'(coef_tab[s][4 + k]);
      d = 64'(coef_tab[s][6 + k]);
      ta = sat_word(mul_floor(a, t));
      cv = sat_word(6 * ta + 2 * b);
      g = sat_word(3 * ta + 2 * b);
      dv = sat_word(mul_floor(g, t) + c);
      h1 = sat_word(ta + b);
      h2 = sat_word(mul_floor(h1, t) + c);
      v = sat_word(mul_floor(h2, t) + d);
      if (k == 0) begin
        r.value_re = v[31:0];
        r.deriv_re = dv[31:0];
        r.curv_re = cv[31:0];
      end else begin
        r.value_im = v[31:0];
        r.deriv_im = dv[31:0];
        r.curv_im = cv[31:0];
      end
    end
    r.seg = s[5:0];
    return r;
  endfunction

  function automatic spline_result_t predict(input logic [IN_W-1:0] d, input logic ext);
    spline_result_t r;
    logic [1:0] act;
    int s;
    logic signed [31:0] x;
    r = '0;
    act = d[1:0];
    s = int'(d[7:2]);
    x = d[39:8];
    case (act)
      ACT_LOAD: begin
        r.seg = s[5:0];
        knot_tab[s] = x;
        for (int k = 0; k < 8; k++) coef_tab[s][k] = d[40 + 32 * k +: 32];
        loaded[s] = 1'b1;
      end
      ACT_SEARCH: begin
        if (!ext && (x < low_reg || x > high_reg)) r.status = 1'b1;
        else r = spline_eval(search_seg(x), x);
      end
      ACT_GIVEN: begin
        if (s > n_active() - 1) s = n_active() - 1;
        r = spline_eval(s, x);
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEGMENT_COUNT: count_reg = val[6:0];
      REG_RANGE_LOW: low_reg = val;
      default: high_reg = val;
    endcase
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_item(input logic [1:0] act, input int s, input logic [31:0] x,
                           input logic [255:0] co, input logic ext);
    logic [IN_W-1:0] d;
    d = {co, x, s[5:0], act};
    while (send_idle && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= ext;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(predict(d, ext));
    @(negedge clk);
  endtask

  function automatic logic [255:0] rand_coeffs(input int scale);
    logic [255:0] c;
    for (int k = 0; k < 8; k++) begin
      if (scale == 0) c[32 * k +: 32] = $urandom;
      else c[32 * k +: 32] = $signed($urandom_range(2 * scale)) - scale;
    end
    return c;
  endfunction

  function automatic int pick_loaded(input int n);
    int s;
    s = $urandom_range(n - 1);
    while (!loaded[s]) s = $urandom_range(n - 1);
    return s;
  endfunction

  // Sets the segment count and range, then loads n segments with ascending knots spaced by step starting at base.
  task automatic load_table(input int n, input int base, input int step, input int scale);
    write_reg(REG_SEGMENT_COUNT, n);
    write_reg(REG_RANGE_LOW, base);
    write_reg(REG_RANGE_HIGH, base + (n - 1) * step);
    for (int i = 0; i < n; i++)
      send_item(ACT_LOAD, i, base + i * step, rand_coeffs(scale), 1'b0);
    wait_drain();
  endtask

  task automatic test_directed();
    logic [255:0] ext_c;
    ext_c = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_item(ACT_LOAD, 0, 32'h8000_0000, ext_c, 1'b0);
    send_item(ACT_LOAD, 63, 32'h7FFF_FFFF, ~ext_c, 1'b1);
    send_item(ACT_GIVEN, 63, 32'h7FFF_FFFF, '0, 1'b0);
    send_item(ACT_GIVEN, 0, 32'h7FFF_FFFF, '1, 1'b1);
    send_item(ACT_SEARCH, 5, 32'h0, '0, 1'b0);
    send_item(ACT_SEARCH, 0, 32'h1, '0, 1'b0);
    send_item(ACT_SEARCH, 0, 32'hFFFF_FFFF, '0, 1'b1);
    send_item(ACT_UNUSED, 7, 32'h1234, '1, 1'b1);
    wait_drain();
    load_table(4, -32'sh0004_0000, 32'h0002_0000, 0);
    send_item(ACT_SEARCH, 0, -32'sh0004_0000, '0, 1'b0);
    send_item(ACT_SEARCH, 0, 32'h0002_0000, '0, 1'b0);
    send_item(ACT_SEARCH, 0, -32'sh0001_8000, '0, 1'b0);
    send_item(ACT_SEARCH, 0, 32'h0003_0000, '0, 1'b0);
    send_item(ACT_SEARCH, 0, 32'h0003_0000, '0, 1'b1);
    send_item(ACT_SEARCH, 0, 32'h8000_0000, '0, 1'b1);
    send_item(ACT_GIVEN, 40, 32'h0, '0, 1'b0);
    wait_drain();
  endtask

  task automatic random_phase(input int n, input int items, input int scale);
    int step, s;
    logic [31:0] x;
    step = $urandom_range(1, 32'h0100_0000 / n);
    load_table(n, $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000, step, scale);
    for (int i = 0; i < items; i++) begin
      s = pick_loaded(n);
      case ($urandom_range(9))
        0: send_item(ACT_LOAD, s, knot_tab[s], rand_coeffs(scale), 1'($urandom));
        1: send_item(ACT_UNUSED, $urandom, $urandom, rand_coeffs(0), 1'($urandom));
        2: send_item(ACT_GIVEN, $urandom_range(63), knot_tab[s] + $urandom_range(step),
                     '0, 1'($urandom));
        3: send_item(ACT_SEARCH, $urandom, $urandom, '0, 1'($urandom));
        default: begin
          x = low_reg + $urandom_range(n * step);
          if ($urandom_range(7) == 0) x = x - 2 * step;
          send_item(ACT_SEARCH, $urandom, x, '0, 1'($urandom));
        end
      endcase
    end
    wait_drain();
  endtask

  task automatic test_random();
    random_phase(1, 150, 0);
    random_phase(64, 500, 32'h0004_0000);
    random_phase(7, 300, 0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_phase(64, 300, 32'h0100_0000);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    random_phase(20, 400, 32'h0010_0000);
    write_reg(REG_SEGMENT_COUNT, 7'd127);
    write_reg(REG_RANGE_LOW, 32'h8000_0000);
    write_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
    for (int i = 0; i < 100; i++)
      send_item(ACT_SEARCH, 0, $urandom, '0, 1'($urandom));
    wait_drain();
    write_reg(REG_SEGMENT_COUNT, 7'd0);
    for (int i = 0; i < 50; i++)
      send_item(ACT_GIVEN, $urandom, $urandom_range(32'hFFFF), '0, 1'($urandom));
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (recv_idle && $urandom_range(99) < 22) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    spline_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[197:0]};
      if (expected_q.size() == 0) begin
        report("unexpected result", got[63:0], 64'h0);
      end else begin
        want = expected_q.pop_front();
        if (got.value_re !== want.value_re)
          report("value_re", 64'(got.value_re), 64'(want.value_re));
        if (got.value_im !== want.value_im)
          report("value_im", 64'(got.value_im), 64'(want.value_im));
        if (got.deriv_re !== want.deriv_re)
          report("deriv_re", 64'(got.deriv_re), 64'(want.deriv_re));
        if (got.deriv_im !== want.deriv_im)
          report("deriv_im", 64'(got.deriv_im), 64'(want.deriv_im));
        if (got.curv_re !== want.curv_re)
          report("curv_re", 64'(got.curv_re), 64'(want.curv_re));
        if (got.curv_im !== want.curv_im)
          report("curv_im", 64'(got.curv_im), 64'(want.curv_im));
        if (got.seg !== want.seg) report("used_segment", 64'(got.seg), 64'(want.seg));
        if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
      end
    end
  end

  initial begin
    count_reg = 7'd1;
    low_reg = 0;
    high_reg = 0;
    for (int i = 0; i < NSEG; i++) begin
      knot_tab[i] = 0;
      loaded[i] = 1'b0;
      for (int k = 0; k < 8; k++) coef_tab[i][k] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    if (errors == 0) $display("complex_cubic_spline_evaluator test passed");
    else $display("complex_cubic_spline_evaluator test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("complex_cubic_spline_evaluator test failed");
    $finish;
  end
endmodule
